### hw/rtl/sbrf_pkg.sv
// Shared constants and transfer payload types for the scoreboarded register file.
`timescale 1ns / 1ps

package sbrf_pkg;

   localparam int REG_COUNT   = 64;
   localparam int INDEX_WIDTH = 6;
   localparam int DATA_WIDTH  = 64;
   localparam int SRC_COUNT   = 3;

   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [DATA_WIDTH-1:0]  data_type;

   typedef struct packed {
      logic      write_enable;
      index_type write_index;
      data_type  write_value;
      index_type dest_index;
      index_type src1_index;
      index_type src2_index;
      index_type src3_index;
      logic      issue_request;
   } req_payload_type;

   typedef struct packed {
      data_type src1_value;
      data_type src2_value;
      data_type src3_value;
      logic     issue_grant;
   } rsp_payload_type;

endpackage

### hw/rtl/sbrf_ram.sv
// Generic one-write one-read memory with registered read data.
`timescale 1ns / 1ps

module sbrf_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_enable,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_enable,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_enable) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_enable) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/scoreboard_register_file_3r1w_unit.sv
// Top level: register file with three read ports, one write port and per-register locks.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_payload (write, sources, issue request)
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_payload (source values, issue grant)
//   csr     | in        | csr_write_enable       | csr_write_data (forwarding enable)
//
// One transfer per cycle on each channel unless stalled; a request goes to the input register,
// whose source reads go through three RAM copies, and then to the result register.
// Per-register fill bits, cleared by reset, make unwritten registers read as zero.
// Stall on rsp holds the result register; req_stall rises only when both registers are full.
`timescale 1ns / 1ps

module scoreboard_register_file_3r1w_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sbrf_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sbrf_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data
);

   logic                      fwd_ff, fwd_in;
   logic                      s1_valid_ff, s1_valid_in;
   sbrf_pkg::req_payload_type s1_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   sbrf_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic [sbrf_pkg::REG_COUNT-1:0] lock_ff, lock_in;
   logic [sbrf_pkg::REG_COUNT-1:0] fill_ff, fill_in;
   logic                      byp_valid_ff, byp_valid_in;
   sbrf_pkg::index_type       byp_index_ff;
   sbrf_pkg::data_type        byp_value_ff;

   logic                accept;
   logic                commit;
   logic                grant;
   logic                dest_allow;
   sbrf_pkg::index_type req_src [sbrf_pkg::SRC_COUNT];
   sbrf_pkg::index_type s1_src  [sbrf_pkg::SRC_COUNT];
   sbrf_pkg::data_type  ram_data [sbrf_pkg::SRC_COUNT];
   sbrf_pkg::data_type  src_value [sbrf_pkg::SRC_COUNT];
   logic [sbrf_pkg::SRC_COUNT-1:0] src_allow;

   assign commit    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !commit;
   assign accept    = req_valid && !req_stall;

   assign req_src[0] = req_payload.src1_index;
   assign req_src[1] = req_payload.src2_index;
   assign req_src[2] = req_payload.src3_index;
   assign s1_src[0]  = s1_ff.src1_index;
   assign s1_src[1]  = s1_ff.src2_index;
   assign s1_src[2]  = s1_ff.src3_index;

   for (genvar g = 0; g < sbrf_pkg::SRC_COUNT; g++) begin : g_port
      sbrf_ram #(
         .DEPTH(sbrf_pkg::REG_COUNT),
         .WIDTH(sbrf_pkg::DATA_WIDTH)
      ) u_ram (
         .clock     (clock),
         .wr_enable (commit && s1_ff.write_enable),
         .wr_addr   (s1_ff.write_index),
         .wr_data   (s1_ff.write_value),
         .rd_enable (accept),
         .rd_addr   (req_src[g]),
         .rd_data   (ram_data[g])
      );
   end

   always_comb begin
      sbrf_pkg::data_type stored;
      logic               locked;
      stored = '0;
      locked = 1'b0;
      for (int i = 0; i < sbrf_pkg::SRC_COUNT; i++) begin
         if (byp_valid_ff && (byp_index_ff == s1_src[i])) begin
            stored = byp_value_ff;
         end else if (fill_ff[s1_src[i]]) begin
            stored = ram_data[i];
         end else begin
            stored = '0;
         end
         locked = lock_ff[s1_src[i]];
         if (locked && fwd_ff) begin
            src_value[i] = s1_ff.write_value;
            src_allow[i] = s1_ff.write_enable && (s1_ff.write_index == s1_src[i]);
         end else begin
            src_value[i] = stored;
            src_allow[i] = !locked;
         end
      end
   end

   assign dest_allow = !lock_ff[s1_ff.dest_index]
                       || (s1_ff.write_enable && (s1_ff.write_index == s1_ff.dest_index));
   assign grant      = s1_ff.issue_request && dest_allow && (&src_allow);

   always_comb begin
      lock_in = lock_ff;
      fill_in = fill_ff;
      if (commit && s1_ff.write_enable) begin
         lock_in[s1_ff.write_index] = 1'b0;
         fill_in[s1_ff.write_index] = 1'b1;
      end
      if (commit && grant) begin
         lock_in[s1_ff.dest_index] = 1'b1;
      end
   end

   always_comb begin
      rsp_in.src1_value  = src_value[0];
      rsp_in.src2_value  = src_value[1];
      rsp_in.src3_value  = src_value[2];
      rsp_in.issue_grant = grant;
   end

   assign fwd_in       = csr_write_enable ? csr_write_data : fwd_ff;
   assign s1_valid_in  = accept ? 1'b1 : (commit ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign byp_valid_in = accept ? (commit && s1_ff.write_enable) : byp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lock_ff      <= '0;
         fill_ff      <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         fwd_ff       <= fwd_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         lock_ff      <= lock_in;
         fill_ff      <= fill_in;
         byp_valid_ff <= byp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff        <= req_payload;
         byp_index_ff <= s1_ff.write_index;
         byp_value_ff <= s1_ff.write_value;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hw/rtl/sbrf_checker.sv
// Port-level checks for the scoreboarded register file, bound to the top level.
`timescale 1ns / 1ps

module sbrf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input sbrf_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input sbrf_pkg::rsp_payload_type rsp_payload,
   input logic                      csr_write_enable,
   input logic                      csr_write_data
);

   logic req_transfer;

   assign req_transfer = req_valid && !req_stall;

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_needs_full_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while result register can drain");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_transfer ##1 !(rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("accepted transfer produced no result");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

endmodule

bind scoreboard_register_file_3r1w_unit sbrf_checker u_sbrf_checker (.*);

### tb/sv/scoreboard_register_file_3r1w_unit_tb.sv
// Self-checking testbench for the scoreboarded three-read, one-write register file.
`timescale 1ns / 1ps

module scoreboard_register_file_3r1w_unit_tb;

   typedef sbrf_pkg::index_type       index_type;
   typedef sbrf_pkg::data_type        data_type;
   typedef sbrf_pkg::req_payload_type req_payload_type;
   typedef sbrf_pkg::rsp_payload_type rsp_payload_type;

   localparam int REG_COUNT = sbrf_pkg::REG_COUNT;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_PHASES = 4;
   localparam int unsigned PHASE_ITEMS = 390;

   localparam data_type ONES   = '1;
   localparam data_type D_ODD  = 64'h0123_4567_89AB_CDEF;
   localparam data_type D_DEAD = 64'hDEAD_BEEF_0000_FFFF;
   localparam data_type D_FIVE = 64'h5555_5555_5555_5555;
   localparam data_type D_AAAA = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam data_type D_EDGE = 64'h8000_0000_0000_0001;
   localparam rsp_payload_type NO_RESULT = '0;

   typedef struct {
      logic            set_fwd;
      logic            fwd_value;
      req_payload_type item;
      logic            typed;
      rsp_payload_type result;
   } directed_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic            csr_write_data = 1'b0;

   data_type reg_data [REG_COUNT];
   logic     reg_busy [REG_COUNT];
   logic     fwd_on;

   rsp_payload_type  issue_results_q [$];
   directed_row_type directed_rows [$];
   rsp_payload_type  wanted;
   int unsigned      idle_pct = 0;
   int unsigned      stall_left = 0;
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;

   scoreboard_register_file_3r1w_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic data_type read_operand(input index_type src, input req_payload_type it,
                                             output logic ok);
      if (!reg_busy[src]) begin
         ok = 1'b1;
         return reg_data[src];
      end
      if (fwd_on) begin
         ok = it.write_enable && (it.write_index == src);
         return it.write_value;
      end
      ok = 1'b0;
      return reg_data[src];
   endfunction

   function automatic rsp_payload_type resolve_issue(input req_payload_type it);
      rsp_payload_type r;
      logic ok1, ok2, ok3, dest_ok;
      r.src1_value = read_operand(it.src1_index, it, ok1);
      r.src2_value = read_operand(it.src2_index, it, ok2);
      r.src3_value = read_operand(it.src3_index, it, ok3);
      dest_ok = !reg_busy[it.dest_index] ||
                (it.write_enable && (it.write_index == it.dest_index));
      r.issue_grant = it.issue_request && dest_ok && ok1 && ok2 && ok3;
      if (it.write_enable) begin
         reg_data[it.write_index] = it.write_value;
         reg_busy[it.write_index] = 1'b0;
      end
      if (r.issue_grant) begin
         reg_busy[it.dest_index] = 1'b1;
      end
      return r;
   endfunction

   function automatic index_type pick_index();
      if ($urandom_range(0, 3) != 0) begin
         return index_type'($urandom_range(0, 7));
      end
      return index_type'($urandom_range(0, REG_COUNT - 1));
   endfunction

   function automatic req_payload_type random_item();
      req_payload_type it;
      int unsigned start;
      it = {$urandom, $urandom, $urandom};
      if ($urandom_range(0, 9) == 0) begin
         return it;
      end
      it.write_enable  = ($urandom_range(0, 9) < 6);
      it.issue_request = ($urandom_range(0, 9) < 8);
      it.dest_index    = pick_index();
      it.src1_index    = pick_index();
      it.src2_index    = pick_index();
      it.src3_index    = pick_index();
      it.write_index   = pick_index();
      // write back a register that is still waiting, as a pipeline would
      if ($urandom_range(0, 9) < 7) begin
         start = $urandom_range(0, REG_COUNT - 1);
         for (int k = 0; k < REG_COUNT; k++) begin
            if (reg_busy[(start + k) % REG_COUNT]) begin
               it.write_index = index_type'((start + k) % REG_COUNT);
               break;
            end
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         it.write_value = ($urandom_range(0, 1) != 0) ? ONES : '0;
      end
      return it;
   endfunction

   task automatic add_row(input logic set_fwd, input logic fwd_value,
                          input req_payload_type item, input logic typed,
                          input rsp_payload_type result);
      directed_row_type row;
      row.set_fwd   = set_fwd;
      row.fwd_value = fwd_value;
      row.item      = item;
      row.typed     = typed;
      row.result    = result;
      directed_rows.push_back(row);
   endtask

   task automatic send_item(input req_payload_type item, input logic typed,
                            input rsp_payload_type typed_result);
      rsp_payload_type predicted;
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = resolve_issue(item);
      issue_results_q.push_back(typed ? typed_result : predicted);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (issue_results_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_forwarding(input logic value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      fwd_on = value;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("scoreboard_register_file_3r1w_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (issue_results_q.size() == 0) begin
               $error("rsp transfer with no result outstanding");
               error_count++;
            end else begin
               wanted = issue_results_q.pop_front();
               if (rsp_payload.src1_value !== wanted.src1_value) begin
                  $error("src1_value: expected %h, actual %h",
                         wanted.src1_value, rsp_payload.src1_value);
                  error_count++;
               end
               if (rsp_payload.src2_value !== wanted.src2_value) begin
                  $error("src2_value: expected %h, actual %h",
                         wanted.src2_value, rsp_payload.src2_value);
                  error_count++;
               end
               if (rsp_payload.src3_value !== wanted.src3_value) begin
                  $error("src3_value: expected %h, actual %h",
                         wanted.src3_value, rsp_payload.src3_value);
                  error_count++;
               end
               if (rsp_payload.issue_grant !== wanted.issue_grant) begin
                  $error("issue_grant: expected %b, actual %b",
                         wanted.issue_grant, rsp_payload.issue_grant);
                  error_count++;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      foreach (reg_data[i]) begin
         reg_data[i] = '0;
         reg_busy[i] = 1'b0;
      end
      fwd_on = 1'b0;

      // forwarding off: plain reads, locks block sources and destinations
      add_row(1'b1, 1'b0, req_payload_type'{1'b0, 6'd0, 64'd0, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0},
              1'b1, rsp_payload_type'{64'd0, 64'd0, 64'd0, 1'b0});
      add_row(1'b0, 1'b0, req_payload_type'{1'b1, 6'd63, ONES, 6'd63, 6'd63, 6'd0, 6'd1, 1'b1},
              1'b1, rsp_payload_type'{64'd0, 64'd0, 64'd0, 1'b1});
      add_row(1'b0, 1'b0, req_payload_type'{1'b0, 6'd0, 64'd0, 6'd1, 6'd63, 6'd2, 6'd3, 1'b1},
              1'b1, rsp_payload_type'{ONES, 64'd0, 64'd0, 1'b0});
      add_row(1'b0, 1'b0, req_payload_type'{1'b1, 6'd63, 64'd0, 6'd63, 6'd0, 6'd0, 6'd0, 1'b1},
              1'b1, rsp_payload_type'{64'd0, 64'd0, 64'd0, 1'b1});
      add_row(1'b0, 1'b0, req_payload_type'{1'b1, 6'd0, ONES, 6'd2, 6'd63, 6'd63, 6'd63, 1'b1},
              1'b1, rsp_payload_type'{64'd0, 64'd0, 64'd0, 1'b0});
      add_row(1'b0, 1'b0, req_payload_type'{1'b1, 6'd63, D_ODD, 6'd2, 6'd0, 6'd63, 6'd62, 1'b0},
              1'b1, rsp_payload_type'{ONES, 64'd0, 64'd0, 1'b0});
      add_row(1'b0, 1'b0, req_payload_type'{1'b0, 6'd0, 64'd0, 6'd62, 6'd63, 6'd0, 6'd63, 1'b1},
              1'b1, rsp_payload_type'{D_ODD, ONES, D_ODD, 1'b1});
      add_row(1'b0, 1'b0, req_payload_type'{1'b0, 6'd0, 64'd0, 6'd62, 6'd1, 6'd2, 6'd3, 1'b1},
              1'b1, rsp_payload_type'{64'd0, 64'd0, 64'd0, 1'b0});
      // forwarding on: locked sources take the write data; the last four rows turn it off again
      add_row(1'b1, 1'b1, req_payload_type'{1'b1, 6'd62, D_DEAD, 6'd5, 6'd62, 6'd62, 6'd62, 1'b1},
              1'b1, rsp_payload_type'{D_DEAD, D_DEAD, D_DEAD, 1'b1});
      add_row(1'b0, 1'b0, req_payload_type'{1'b1, 6'd7, D_FIVE, 6'd6, 6'd5, 6'd0, 6'd63, 1'b1},
              1'b1, rsp_payload_type'{D_FIVE, ONES, D_ODD, 1'b0});
      add_row(1'b0, 1'b0, req_payload_type'{1'b0, 6'd5, D_AAAA, 6'd5, 6'd5, 6'd7, 6'd62, 1'b1},
              1'b1, rsp_payload_type'{D_AAAA, D_FIVE, D_DEAD, 1'b0});
      add_row(1'b0, 1'b0, req_payload_type'{1'b1, 6'd5, 64'd1, 6'd5, 6'd5, 6'd5, 6'd1, 1'b1},
              1'b1, rsp_payload_type'{64'd1, 64'd1, 64'd0, 1'b1});
      add_row(1'b0, 1'b0, req_payload_type'{1'b0, 6'd0, 64'd0, 6'd0, 6'd5, 6'd5, 6'd5, 1'b0},
              1'b1, rsp_payload_type'{64'd0, 64'd0, 64'd0, 1'b0});
      add_row(1'b0, 1'b0, req_payload_type'{1'b1, 6'd5, ONES, 6'd0, 6'd5, 6'd0, 6'd62, 1'b0},
              1'b1, rsp_payload_type'{ONES, ONES, D_DEAD, 1'b0});
      add_row(1'b1, 1'b0, req_payload_type'{1'b1, 6'd63, D_EDGE, 6'd63, 6'd5, 6'd7, 6'd63, 1'b1},
              1'b0, NO_RESULT);
      add_row(1'b0, 1'b0, req_payload_type'{1'b1, 6'd0, 64'd0, 6'd0, 6'd62, 6'd1, 6'd0, 1'b1},
              1'b0, NO_RESULT);
      add_row(1'b0, 1'b0, req_payload_type'{1'b0, 6'd0, 64'd0, 6'd4, 6'd63, 6'd63, 6'd0, 1'b1},
              1'b0, NO_RESULT);
      add_row(1'b0, 1'b0, req_payload_type'{1'b1, 6'd63, ONES, 6'd1, 6'd63, 6'd0, 6'd0, 1'b1},
              1'b0, NO_RESULT);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 25;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_fwd) begin
            write_forwarding(directed_rows[i].fwd_value);
         end
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_forwarding(phase % 2 == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) begin
               case ($urandom_range(0, 2))
                  0: idle_pct = 0;
                  1: idle_pct = 15;
                  default: idle_pct = 40;
               endcase
            end
            if (phase == RANDOM_PHASES - 1 && n >= PHASE_ITEMS / 2) begin
               idle_pct = 0;
            end
            send_item(random_item(), 1'b0, NO_RESULT);
         end
      end

      settle();
      if (error_count == 0) begin
         $display("scoreboard_register_file_3r1w_unit: match");
      end else begin
         $display("scoreboard_register_file_3r1w_unit: mismatch");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/sbrf_pkg.sv
hw/rtl/sbrf_ram.sv
hw/rtl/scoreboard_register_file_3r1w_unit.sv
hw/rtl/sbrf_checker.sv
tb/sv/scoreboard_register_file_3r1w_unit_tb.sv
